@@ rtl/shade_pkg.sv @@
package shade_pkg;

  // algorithm codes of the mode register
  localparam logic [1:0] MODE_SHA1   = 2'd0;
  localparam logic [1:0] MODE_SHA256 = 2'd1;
  localparam logic [1:0] MODE_SHA512 = 2'd2;
  localparam logic [1:0] MODE_RESET  = MODE_SHA256;

  typedef logic [63:0] dword_t;
  typedef logic [7:0][63:0] wvec_t;

  // round control handed to the round unit
  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] rnd;
  } rctl_t;

  localparam dword_t K64_TABLE [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  localparam dword_t IV64_TABLE [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam logic [31:0] IV_SHA1_TABLE [8] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0,
    32'h0, 32'h0, 32'h0
  };

  localparam logic [31:0] K_SHA1_0 = 32'h5A827999;
  localparam logic [31:0] K_SHA1_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_SHA1_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_SHA1_3 = 32'hCA62C1D6;

  function automatic dword_t k64(input logic [6:0] r);
    dword_t v;
    if (r < 7'd80) v = K64_TABLE[r];
    else v = '0;
    return v;
  endfunction

  function automatic logic [31:0] k_sha1(input logic [6:0] r);
    logic [31:0] v;
    if (r < 7'd20) v = K_SHA1_0;
    else if (r < 7'd40) v = K_SHA1_1;
    else if (r < 7'd60) v = K_SHA1_2;
    else v = K_SHA1_3;
    return v;
  endfunction

  // initial chaining value of one entry for a mode
  function automatic dword_t iv(input logic [1:0] mode, input logic [2:0] i);
    dword_t v;
    case (mode)
      MODE_SHA1:   v = {32'h0, IV_SHA1_TABLE[i]};
      MODE_SHA256: v = {32'h0, IV64_TABLE[i][63:32]};
      default:     v = IV64_TABLE[i];
    endcase
    return v;
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic dword_t rotr64(input dword_t x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

@@ rtl/shade_in_if.sv @@
interface shade_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

@@ rtl/shade_out_if.sv @@
interface shade_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        last_word;

  modport source (output valid, digest_word, last_word, input ready);
  modport sink (input valid, digest_word, last_word, output ready);
endinterface

@@ rtl/shade_round.sv @@
module shade_round (
  input  shade_pkg::rctl_t  ctl,
  input  shade_pkg::wvec_t  wv,
  input  shade_pkg::dword_t hkw,
  input  shade_pkg::dword_t x0,
  input  shade_pkg::dword_t x1,
  input  shade_pkg::dword_t q0,
  input  shade_pkg::dword_t q1,
  output shade_pkg::dword_t w,
  output shade_pkg::wvec_t  wv_next
);

  // schedule word: x0 = w[t-16], x1 = w[t-7] (sha-1: w[t-8]), q0/q1 the other two taps
  always_comb begin
    logic [31:0] g0s;
    logic [31:0] g1s;
    shade_pkg::dword_t g0l;
    shade_pkg::dword_t g1l;
    g0s = shade_pkg::rotr32(q0[31:0], 7) ^ shade_pkg::rotr32(q0[31:0], 18) ^ (q0[31:0] >> 3);
    g1s = shade_pkg::rotr32(q1[31:0], 17) ^ shade_pkg::rotr32(q1[31:0], 19) ^ (q1[31:0] >> 10);
    g0l = shade_pkg::rotr64(q0, 1) ^ shade_pkg::rotr64(q0, 8) ^ (q0 >> 7);
    g1l = shade_pkg::rotr64(q1, 19) ^ shade_pkg::rotr64(q1, 61) ^ (q1 >> 6);
    if (ctl.rnd < 7'd16) begin
      w = (ctl.mode == shade_pkg::MODE_SHA512) ? x0 : {32'h0, x0[31:0]};
    end else begin
      case (ctl.mode)
        shade_pkg::MODE_SHA1:
          w = {32'h0, shade_pkg::rotr32(x0[31:0] ^ x1[31:0] ^ q0[31:0] ^ q1[31:0], 31)};
        shade_pkg::MODE_SHA256:
          w = {32'h0, x0[31:0] + g0s + x1[31:0] + g1s};
        default:
          w = x0 + g0l + x1 + g1l;
      endcase
    end
  end

  // one compression round; hkw already holds h (sha-1: e) + k + w
  always_comb begin
    logic [31:0] a, b, c, d, e, f, g, t1s, s0s, s1s, chs, mjs, fs;
    shade_pkg::dword_t t1l, s0l, s1l, chl, mjl;
    a = wv[0][31:0];
    b = wv[1][31:0];
    c = wv[2][31:0];
    d = wv[3][31:0];
    e = wv[4][31:0];
    f = wv[5][31:0];
    g = wv[6][31:0];
    s1s = shade_pkg::rotr32(e, 6) ^ shade_pkg::rotr32(e, 11) ^ shade_pkg::rotr32(e, 25);
    chs = (e & f) ^ (~e & g);
    t1s = hkw[31:0] + s1s + chs;
    s0s = shade_pkg::rotr32(a, 2) ^ shade_pkg::rotr32(a, 13) ^ shade_pkg::rotr32(a, 22);
    mjs = (a & b) ^ (a & c) ^ (b & c);
    s1l = shade_pkg::rotr64(wv[4], 14) ^ shade_pkg::rotr64(wv[4], 18)
        ^ shade_pkg::rotr64(wv[4], 41);
    chl = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
    t1l = hkw + s1l + chl;
    s0l = shade_pkg::rotr64(wv[0], 28) ^ shade_pkg::rotr64(wv[0], 34)
        ^ shade_pkg::rotr64(wv[0], 39);
    mjl = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
    if (ctl.rnd < 7'd20) fs = (b & c) | (~b & d);
    else if (ctl.rnd < 7'd40) fs = b ^ c ^ d;
    else if (ctl.rnd < 7'd60) fs = (b & c) | (b & d) | (c & d);
    else fs = b ^ c ^ d;
    wv_next = wv;
    case (ctl.mode)
      shade_pkg::MODE_SHA1: begin
        wv_next[4] = {32'h0, d};
        wv_next[3] = {32'h0, c};
        wv_next[2] = {32'h0, shade_pkg::rotr32(b, 2)};
        wv_next[1] = {32'h0, a};
        wv_next[0] = {32'h0, shade_pkg::rotr32(a, 27) + fs + hkw[31:0]};
      end
      shade_pkg::MODE_SHA256: begin
        wv_next[7] = {32'h0, g};
        wv_next[6] = {32'h0, f};
        wv_next[5] = {32'h0, e};
        wv_next[4] = {32'h0, d + t1s};
        wv_next[3] = {32'h0, c};
        wv_next[2] = {32'h0, b};
        wv_next[1] = {32'h0, a};
        wv_next[0] = {32'h0, t1s + s0s + mjs};
      end
      default: begin
        wv_next[7] = wv[6];
        wv_next[6] = wv[5];
        wv_next[5] = wv[4];
        wv_next[4] = wv[3] + t1l;
        wv_next[3] = wv[2];
        wv_next[2] = wv[1];
        wv_next[1] = wv[0];
        wv_next[0] = t1l + s0l + mjl;
      end
    endcase
  end

endmodule

@@ rtl/sha1_sha2_digest_engine_top.sv @@
// input: one byte transfer per cycle while gathering; a full block then stalls input
// while the chaining value is read in, the rounds run and the sum is written back; each
// round is split in phases as it reads the schedule memory twice over its two read ports
// end of message: padding one byte per cycle plus one or two block compressions,
// then each digest word is read, loaded and held on the output until it is taken
// reset (rst, synchronous): sha-256 mode, empty message, no memory clearing pass
module sha1_sha2_digest_engine_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  shade_in_if.sink          msg_in,
  shade_out_if.source       digest_out
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_CV_RD, S_RND, S_CV_WR, S_OUT_RD, S_OUT_LD, S_OUT_WT
  } state_t;

  typedef enum logic [1:0] {PP_MARK, PP_ZERO, PP_LEN} pad_t;

  state_t            state;
  pad_t              pad_ph;
  logic [1:0]        mode;
  logic [60:0]       cnt;
  logic [6:0]        pos;
  shade_pkg::dword_t acc;
  logic              first;       // chaining value still the initial vector
  logic              padding;
  logic              finishing;   // length bytes placed, digest follows the compression
  logic [3:0]        k;
  logic [6:0]        rnd;
  logic [2:0]        ph;
  shade_pkg::wvec_t  wv;
  shade_pkg::dword_t x0, x1, wreg, hkw;
  logic [3:0]        j;
  logic              out_valid;
  logic [31:0]       out_word;
  logic              out_last;

  // schedule window / block buffer and chaining value memories
  shade_pkg::dword_t sched_mem [16];
  shade_pkg::dword_t sched_rd0, sched_rd1;
  shade_pkg::dword_t cv_mem [8];
  shade_pkg::dword_t cv_rd;

  logic              m512;
  logic [6:0]        bl_last, len_start, rnd_last, from_end, pos_after;
  logic [3:0]        words_last;
  logic              in_xfer, out_xfer, place_en, full;
  logic [7:0]        place_byte, pad_byte;
  logic [3:0]        widx;
  shade_pkg::dword_t acc_next, bits, w, hkw_c, cv_in, cv_sum;
  shade_pkg::wvec_t  wv_next;
  logic [3:0]        ra0, ra1, wa;
  logic              swe;
  shade_pkg::dword_t wd;
  logic [2:0]        cra, kp;
  shade_pkg::rctl_t  ctl;

  assign m512       = (mode == shade_pkg::MODE_SHA512);
  assign bl_last    = m512 ? 7'd127 : 7'd63;
  assign len_start  = m512 ? 7'd112 : 7'd56;
  assign rnd_last   = (mode == shade_pkg::MODE_SHA256) ? 7'd63 : 7'd79;
  assign words_last = m512 ? 4'd15 : ((mode == shade_pkg::MODE_SHA1) ? 4'd4 : 4'd7);

  assign in_xfer  = msg_in.valid && msg_in.ready;
  assign out_xfer = digest_out.valid && digest_out.ready;

  // padding byte: marker, zeros, then the big-endian bit length
  assign bits     = {cnt, 3'b000};
  assign from_end = bl_last - pos;
  always_comb begin
    case (pad_ph)
      PP_MARK: pad_byte = 8'h80;
      PP_ZERO: pad_byte = 8'h00;
      default: begin
        if (from_end < 7'd8) pad_byte = 8'(bits >> {from_end[2:0], 3'b000});
        else pad_byte = 8'h00;
      end
    endcase
  end

  assign place_en   = (state == S_IDLE) ? (in_xfer && msg_in.byte_present) : (state == S_PAD);
  assign place_byte = (state == S_IDLE) ? msg_in.data_byte : pad_byte;
  assign full       = (pos == bl_last);
  assign pos_after  = full ? 7'd0 : pos + 7'd1;
  assign widx       = m512 ? pos[6:3] : pos[5:2];

  // byte packing into the current big-endian word
  always_comb begin
    if (m512) begin
      acc_next = (pos[2:0] == 3'd0) ? {56'h0, place_byte} : {acc[55:0], place_byte};
    end else begin
      acc_next = (pos[1:0] == 2'd0) ? {56'h0, place_byte} : {32'h0, acc[23:0], place_byte};
    end
  end

  // schedule taps: first pair w[t-16] and w[t-7] (sha-1 w[t-8]), second pair the rest
  always_comb begin
    if (ph == 3'd0) begin
      ra0 = rnd[3:0];
      ra1 = rnd[3:0] + ((mode == shade_pkg::MODE_SHA1) ? 4'd8 : 4'd9);
    end else begin
      ra0 = rnd[3:0] + ((mode == shade_pkg::MODE_SHA1) ? 4'd13 : 4'd1);
      ra1 = rnd[3:0] + ((mode == shade_pkg::MODE_SHA1) ? 4'd2 : 4'd14);
    end
  end

  assign swe = place_en || ((state == S_RND) && (ph == 3'd3));
  assign wa  = place_en ? widx : rnd[3:0];
  assign wd  = place_en ? acc_next : wreg;

  always_ff @(posedge clk) begin
    if (swe) begin
      sched_mem[wa] <= wd;
    end
    sched_rd0 <= sched_mem[ra0];
    sched_rd1 <= sched_mem[ra1];
  end

  // chaining value: the initial vector stands in until the first block is folded in
  assign kp     = 3'(k - 4'd1);
  assign cra    = (state == S_OUT_RD) ? (m512 ? j[3:1] : j[2:0]) : k[2:0];
  assign cv_in  = first ? shade_pkg::iv(mode, kp) : cv_rd;
  assign cv_sum = m512 ? (cv_in + wv[0]) : {32'h0, cv_in[31:0] + wv[0][31:0]};

  always_ff @(posedge clk) begin
    if ((state == S_CV_WR) && (k != 4'd0)) begin
      cv_mem[kp] <= cv_sum;
    end
    cv_rd <= cv_mem[cra];
  end

  // h + k + w ahead of the round (sha-1 folds e instead of h)
  always_comb begin
    shade_pkg::dword_t kr;
    kr = shade_pkg::k64(rnd);
    case (mode)
      shade_pkg::MODE_SHA1:
        hkw_c = {32'h0, wv[4][31:0] + shade_pkg::k_sha1(rnd) + wreg[31:0]};
      shade_pkg::MODE_SHA256:
        hkw_c = {32'h0, wv[7][31:0] + kr[63:32] + wreg[31:0]};
      default:
        hkw_c = wv[7] + kr + wreg;
    endcase
  end

  assign ctl.mode = mode;
  assign ctl.rnd  = rnd;

  shade_round u_round (
    .ctl     (ctl),
    .wv      (wv),
    .hkw     (hkw),
    .x0      (x0),
    .x1      (x1),
    .q0      (sched_rd0),
    .q1      (sched_rd1),
    .w       (w),
    .wv_next (wv_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pad_ph    <= PP_MARK;
      mode      <= shade_pkg::MODE_RESET;
      cnt       <= '0;
      pos       <= '0;
      first     <= 1'b1;
      padding   <= 1'b0;
      finishing <= 1'b0;
      k         <= '0;
      rnd       <= '0;
      ph        <= '0;
      j         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (place_en) begin
        acc <= acc_next;
        pos <= pos_after;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            if (msg_in.byte_present) begin
              cnt <= cnt + 61'd1;
            end
            if (msg_in.end_of_message) begin
              padding <= 1'b1;
              pad_ph  <= PP_MARK;
            end
            if (msg_in.byte_present && full) begin
              k     <= '0;
              state <= S_CV_RD;
            end else if (msg_in.end_of_message) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (pad_ph == PP_LEN) begin
            if (full) finishing <= 1'b1;
          end else if (pos_after == len_start) begin
            pad_ph <= PP_LEN;
          end else begin
            pad_ph <= PP_ZERO;
          end
          if (full) begin
            k     <= '0;
            state <= S_CV_RD;
          end
        end
        S_CV_RD: begin
          if (k != 4'd0) begin
            wv <= {cv_in, wv[7:1]};
          end
          if (k == 4'd8) begin
            rnd   <= '0;
            ph    <= '0;
            state <= S_RND;
          end else begin
            k <= k + 4'd1;
          end
        end
        S_RND: begin
          case (ph)
            3'd0: ph <= 3'd1;
            3'd1: begin
              x0 <= sched_rd0;
              x1 <= sched_rd1;
              ph <= 3'd2;
            end
            3'd2: begin
              wreg <= w;
              ph   <= 3'd3;
            end
            3'd3: begin
              hkw <= hkw_c;
              ph  <= 3'd4;
            end
            default: begin
              wv <= wv_next;
              ph <= 3'd0;
              if (rnd == rnd_last) begin
                rnd   <= '0;
                k     <= '0;
                state <= S_CV_WR;
              end else begin
                rnd <= rnd + 7'd1;
              end
            end
          endcase
        end
        S_CV_WR: begin
          if (k != 4'd0) begin
            wv <= {64'h0, wv[7:1]};
          end
          if (k == 4'd8) begin
            first <= 1'b0;
            if (!padding) begin
              state <= S_IDLE;
            end else if (finishing) begin
              j     <= '0;
              state <= S_OUT_RD;
            end else begin
              state <= S_PAD;
            end
          end else begin
            k <= k + 4'd1;
          end
        end
        S_OUT_RD: state <= S_OUT_LD;
        S_OUT_LD: begin
          out_word  <= (m512 && !j[0]) ? cv_rd[63:32] : cv_rd[31:0];
          out_last  <= (j == words_last);
          out_valid <= 1'b1;
          state     <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (out_xfer) begin
            out_valid <= 1'b0;
            if (out_last) begin
              first     <= 1'b1;
              cnt       <= '0;
              pos       <= '0;
              padding   <= 1'b0;
              finishing <= 1'b0;
              state     <= S_IDLE;
            end else begin
              j     <= j + 4'd1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // mode write clears the byte count, block position and chaining value; code 3 is dropped
      if (cfg_wr_en && (cfg_wr_data inside {shade_pkg::MODE_SHA1, shade_pkg::MODE_SHA256,
                                            shade_pkg::MODE_SHA512})) begin
        mode  <= cfg_wr_data;
        first <= 1'b1;
        cnt   <= '0;
        pos   <= '0;
      end
    end
  end

  assign msg_in.ready           = (state == S_IDLE);
  assign digest_out.valid       = out_valid;
  assign digest_out.digest_word = out_word;
  assign digest_out.last_word   = out_last;

endmodule

@@ rtl/shade_checker.sv @@
module shade_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_eom,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_word,
  input logic        out_last
);

  // a stalled digest word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("digest word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))
    else $error("digest word changed while stalled");

  // no new byte is taken while a digest word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && in_ready))
    else $error("input ready while digest pending");

  // end of message starts padding, so input closes at once
  a_eom_close: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_eom |=> !in_ready)
    else $error("input still open after end of message");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> !out_valid)
    else $error("digest word after the last one");

endmodule

bind sha1_sha2_digest_engine_top shade_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (msg_in.valid),
  .in_ready  (msg_in.ready),
  .in_eom    (msg_in.end_of_message),
  .out_valid (digest_out.valid),
  .out_ready (digest_out.ready),
  .out_word  (digest_out.digest_word),
  .out_last  (digest_out.last_word)
);
